// ===== src/tws_pkg.sv =====
// Shared types and constants for the three-wire SPI master shifter.
`default_nettype none
package tws_pkg;

	localparam int MAX_BITS_DEF = 32;
	localparam int RX_BITS_DEF = 16;
	localparam int FIFO_DEPTH = 2;
	localparam int PADDR_W = 3;
	localparam logic [15:0] HALF_PERIOD_RST = 16'd100;

	// Register byte addresses
	localparam logic [PADDR_W-1:0] ADDR_HALF_PERIOD = 3'd0;

	// Input op codes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SEND = 2'd1;
	localparam logic [1:0] OP_XFER = 2'd2;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_SEND,
		CMD_XFER
	} cmd_t;

	// One classified beat as it sits in the queue
	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] tx_data;
		logic [7:0]  bit_count;
		logic        len_ok;
		logic        clock_phase;
		logic        dio_in;
	} item_t;

endpackage
`default_nettype wire

// ===== src/tws_front.sv =====
// Input side: decodes each beat and holds it in a short queue for the sequencer.
`default_nettype none
module tws_front import tws_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] tx_data,
	input  wire logic [7:0]  bit_count,
	input  wire logic        clock_phase,
	input  wire logic        dio_in,
	output logic             q_valid,
	output item_t            q_item,
	input  wire logic        q_pop
);

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	item_t           mem_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;
	item_t           dec;
	logic            push;

	always_comb begin
		dec.tx_data     = tx_data;
		dec.bit_count   = bit_count;
		dec.clock_phase = clock_phase;
		dec.dio_in      = dio_in;
		dec.len_ok      = (bit_count != 8'd0) && (bit_count <= 8'(MAX_BITS));
		case (op)
			OP_SEND: dec.cmd = CMD_SEND;
			OP_XFER: dec.cmd = CMD_XFER;
			default: dec.cmd = CMD_TICK;
		endcase
	end

	assign in_ready = (fill_q != CW'(FIFO_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, q_pop})
				2'b10:   fill_q <= fill_q + CW'(1);
				2'b01:   fill_q <= fill_q - CW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/tws_back.sv =====
// Pin sequencer: one queued beat per step, result held in an output register.
`default_nettype none
module tws_back import tws_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEF,
	parameter int RX_BITS  = RX_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] half_period_ticks,
	input  wire logic        q_valid,
	input  wire item_t       q_item,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             cs_n,
	output logic             sck,
	output logic             dio_out,
	output logic             busy_res,
	output logic [15:0]      rx_data,
	output logic             rx_valid
);

	localparam int SW  = (MAX_BITS > RX_BITS) ? MAX_BITS : RX_BITS;
	localparam int BLW = $clog2(SW + 1);
	localparam int IW  = $clog2(SW);

	localparam logic [1:0] MODE_SEND0 = 2'd0;
	localparam logic [1:0] MODE_SEND1 = 2'd1;
	localparam logic [1:0] MODE_XFER  = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SETUP,
		PH_FIRST,
		PH_SECOND,
		PH_HOLD
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [15:0]        tick_q, tick_n;
	logic [BLW-1:0]     bits_q, bits_n;
	logic [SW-1:0]      sw_q, sw_n;
	logic [RX_BITS-1:0] rw_q, rw_n;
	logic [1:0]         mode_q, mode_n;
	logic               cs_q, cs_n_nx;
	logic               sck_q, sck_n;
	logic               dio_q, dio_n;
	logic               rxv_n;
	logic [15:0]        rx_n;
	logic [15:0]        reload;
	logic [BLW-1:0]     bm1;
	logic [BLW-1:0]     bm2;
	logic               bit_setup;
	logic               bit_next;

	assign q_pop  = q_valid && (!out_valid || out_ready);
	assign reload = (half_period_ticks == 16'd0) ? 16'd0 : half_period_ticks - 16'd1;
	assign bm1    = bits_q - BLW'(1);
	assign bm2    = bits_q - BLW'(2);
	// bit on the line when a first half starts from setup, and after a bit ends
	assign bit_setup = sw_q[bm1[IW-1:0]];
	assign bit_next  = sw_q[bm2[IW-1:0]];

	always_comb begin
		phase_n = phase_q;
		tick_n  = tick_q;
		bits_n  = bits_q;
		sw_n    = sw_q;
		rw_n    = rw_q;
		mode_n  = mode_q;
		cs_n_nx = cs_q;
		sck_n   = sck_q;
		dio_n   = dio_q;
		rxv_n   = 1'b0;
		rx_n    = 16'd0;
		if (phase_q == PH_IDLE) begin
			if (q_item.cmd == CMD_SEND || q_item.cmd == CMD_XFER) begin
				rw_n = '0;
				if (q_item.cmd == CMD_SEND) begin
					mode_n = q_item.clock_phase ? MODE_SEND1 : MODE_SEND0;
					sw_n   = SW'(q_item.tx_data);
					bits_n = q_item.len_ok ? q_item.bit_count[BLW-1:0] : '0;
				end else begin
					mode_n = MODE_XFER;
					sw_n   = SW'(q_item.tx_data[RX_BITS-1:0]);
					bits_n = BLW'(RX_BITS);
				end
				cs_n_nx = 1'b0;
				sck_n   = 1'b0;
				dio_n   = 1'b0;
				phase_n = PH_SETUP;
				tick_n  = reload;
			end
		end else if (tick_q != 16'd0) begin
			tick_n = tick_q - 16'd1;
		end else begin
			tick_n = reload;
			case (phase_q)
				PH_SETUP: begin
					if (bits_q == '0) begin
						phase_n = PH_HOLD;
					end else begin
						dio_n   = bit_setup;
						sck_n   = (mode_q == MODE_SEND0);
						phase_n = PH_FIRST;
					end
				end
				PH_FIRST: begin
					sck_n = (mode_q != MODE_SEND0);
					if (mode_q == MODE_XFER) begin
						rw_n = {rw_q[RX_BITS-2:0], q_item.dio_in};
					end
					phase_n = PH_SECOND;
				end
				PH_SECOND: begin
					bits_n = bm1;
					if (mode_q == MODE_XFER) begin
						sck_n = 1'b0;
					end
					if (bm1 != '0) begin
						dio_n   = bit_next;
						sck_n   = (mode_q == MODE_SEND0);
						phase_n = PH_FIRST;
					end else begin
						phase_n = PH_HOLD;
					end
				end
				default: begin
					if (mode_q == MODE_XFER) begin
						rxv_n = 1'b1;
						rx_n  = 16'(rw_q);
					end
					cs_n_nx = 1'b1;
					sck_n   = 1'b0;
					dio_n   = 1'b0;
					phase_n = PH_IDLE;
					tick_n  = 16'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			bits_q    <= '0;
			sw_q      <= '0;
			rw_q      <= '0;
			mode_q    <= MODE_SEND0;
			cs_q      <= 1'b1;
			sck_q     <= 1'b0;
			dio_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q   <= phase_n;
				tick_q    <= tick_n;
				bits_q    <= bits_n;
				sw_q      <= sw_n;
				rw_q      <= rw_n;
				mode_q    <= mode_n;
				cs_q      <= cs_n_nx;
				sck_q     <= sck_n;
				dio_q     <= dio_n;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result payload, loaded with each step
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cs_n     <= cs_n_nx;
			sck      <= sck_n;
			dio_out  <= dio_n;
			busy_res <= (phase_n != PH_IDLE);
			rx_data  <= rx_n;
			rx_valid <= rxv_n;
		end
	end

endmodule
`default_nettype wire

// ===== src/three_wire_spi_master_shifter_top.sv =====
// Top level of the three-wire SPI master shifter: register port, queue and sequencer.
`default_nettype none
// Three-wire SPI master pin sequencer. Each input beat is one tick of the
// sequencer and yields exactly one output beat with the pin levels (cs_n, sck,
// dio_out), busy_res and, at the end of a framed RX_BITS-bit transfer, rx_data with
// rx_valid. op 1 frames a send of 1..MAX_BITS bits MSB first (any other length
// gives setup and hold only), op 2 a framed RX_BITS-bit transfer sampling dio_in
// at each rising sck; commands are ignored while busy. Every half bit and the
// chip-select setup and hold delays last half_period_ticks ticks (0 acts as 1),
// set over the APB port at byte address 0. Rate: one beat per clock cycle,
// sustained, with both sides free to stall. A decode stage feeds a two-entry
// queue; the sequencer takes one beat from the queue per cycle whenever its
// output register is empty or being emptied. An accepted beat is written into
// the queue and then taken from it into the output register; the queue lets
// the input keep flowing for two beats while the output is held.
module three_wire_spi_master_shifter_top import tws_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEF,
	parameter int RX_BITS  = RX_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// input beats
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         op,
	input  wire logic [31:0]        tx_data,
	input  wire logic [7:0]         bit_count,
	input  wire logic               clock_phase,
	input  wire logic               dio_in,
	// output beats
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    cs_n,
	output logic                    sck,
	output logic                    dio_out,
	output logic                    busy_res,
	output logic [15:0]             rx_data,
	output logic                    rx_valid
);

	logic [15:0] half_period_q;
	logic        q_valid;
	logic        q_pop;
	item_t       q_item;

	// APB register: zero wait states, write on the access phase
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_HALF_PERIOD) ? {16'd0, half_period_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_HALF_PERIOD) begin
			half_period_q <= pwdata[15:0];
		end
	end

	// decode and queue
	tws_front #(
		.MAX_BITS(MAX_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.tx_data    (tx_data),
		.bit_count  (bit_count),
		.clock_phase(clock_phase),
		.dio_in     (dio_in),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	// pin sequencer and output register
	tws_back #(
		.MAX_BITS(MAX_BITS),
		.RX_BITS (RX_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.half_period_ticks(half_period_q),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.cs_n             (cs_n),
		.sck              (sck),
		.dio_out          (dio_out),
		.busy_res         (busy_res),
		.rx_data          (rx_data),
		.rx_valid         (rx_valid)
	);

	// Idle pins: chip select high, clock and data low.
	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !busy_res) |-> (cs_n && !sck && !dio_out))
		else $error("idle beat with active pin levels");

	// A received word is only reported on the beat that closes the frame.
	a_rx_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rx_valid) |-> (!busy_res && cs_n))
		else $error("rx_valid while frame still open");

	// rx_data reads zero unless a word is reported.
	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !rx_valid) |-> (rx_data == 16'd0))
		else $error("rx_data nonzero without rx_valid");

	// A frame in progress always holds chip select low.
	a_busy_cs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && busy_res) |-> !cs_n)
		else $error("busy with chip select high");

endmodule
`default_nettype wire
